// ===== sv/arm_pkg.sv =====
// Shared constants and control types for the array mode finder.
package arm_pkg;

  localparam int unsigned MAX_ELEMENTS_DEF = 1024;
  localparam int unsigned VALUE_W          = 32;
  localparam int unsigned MODE_COUNT_W     = 11;

  // Command codes carried on the input channel
  localparam logic CMD_PUSH   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // Reported value for an empty set
  localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

  // Requests from the channel side to the scan core
  typedef struct packed {
    logic push;   // write one element at the fill position
    logic start;  // begin a scan over the loaded elements
  } arm_ctl_t;

  // Status from the scan core
  typedef struct packed {
    logic busy;   // scan in progress
    logic done;   // one-cycle pulse, result fields valid
  } arm_sts_t;

endpackage

// ===== sv/arm_core.sv =====
// Element store and pairwise-count scan sequencer.
module arm_core #(
  parameter int unsigned MAX_ELEMENTS = arm_pkg::MAX_ELEMENTS_DEF,
  parameter int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
  parameter int unsigned CW = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  arm_pkg::arm_ctl_t                     ctl,
  input  logic [AW-1:0]                         wr_addr,
  input  logic signed [arm_pkg::VALUE_W-1:0]    wr_data,
  input  logic [CW-1:0]                         num_elems,
  output arm_pkg::arm_sts_t                     sts,
  output logic signed [arm_pkg::VALUE_W-1:0]    best_value,
  output logic [CW-1:0]                         best_count
);
  import arm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PIVOT,
    S_COUNT
  } state_t;

  logic signed [VALUE_W-1:0] mem [MAX_ELEMENTS];
  logic signed [VALUE_W-1:0] rd_data_r;
  logic [AW-1:0]             rd_addr;

  state_t                    state_r;
  logic [AW-1:0]             i_r;
  logic [AW-1:0]             j_r;
  logic [AW-1:0]             last_r;
  logic signed [VALUE_W-1:0] pivot_r;
  logic [CW-1:0]             run_r;
  logic [CW-1:0]             best_cnt_r;
  logic signed [VALUE_W-1:0] best_val_r;
  logic                      done_r;

  logic                      match;
  logic [CW-1:0]             cnt_new;
  logic [CW-1:0]             num_m1;
  logic                      inner_last;

  // Pushes and scans never overlap, so no forwarding is needed on the store.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign match      = (rd_data_r == pivot_r);
  assign cnt_new    = run_r + CW'(match);
  assign num_m1     = num_elems - CW'(1);
  assign inner_last = (j_r == last_r);

  always_comb begin
    unique case (state_r)
      S_IDLE:  rd_addr = '0;
      S_PIVOT: rd_addr = '0;
      S_COUNT: rd_addr = inner_last ? AW'(i_r + 1'b1) : AW'(j_r + 1'b1);
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      done_r     <= 1'b0;
      i_r        <= '0;
      j_r        <= '0;
      run_r      <= '0;
      best_cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (ctl.start) begin
            last_r     <= num_m1[AW-1:0];
            i_r        <= '0;
            best_cnt_r <= '0;
            state_r    <= S_PIVOT;
          end
        end
        S_PIVOT: begin
          pivot_r <= rd_data_r;
          j_r     <= '0;
          run_r   <= '0;
          state_r <= S_COUNT;
        end
        S_COUNT: begin
          if (inner_last) begin
            if (cnt_new > best_cnt_r) begin
              best_cnt_r <= cnt_new;
              best_val_r <= pivot_r;
            end
            if (i_r == last_r) begin
              done_r  <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              i_r     <= AW'(i_r + 1'b1);
              state_r <= S_PIVOT;
            end
          end else begin
            run_r <= cnt_new;
            j_r   <= AW'(j_r + 1'b1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign sts.busy   = (state_r != S_IDLE);
  assign sts.done   = done_r;
  assign best_value = best_val_r;
  assign best_count = best_cnt_r;

endmodule

// ===== sv/array_mode_finder.sv =====
// Top level of the array mode finder: channel handshakes, fill tracking, result register.
//
//  channel | ports                                        | word
//  --------+----------------------------------------------+--------------------------------
//  input   | in_valid, in_stall, in_command, in_value     | push one element / finish set
//  result  | out_valid, out_stall, out_mode_value,        | mode, its count and flags,
//          | out_mode_count, out_set_empty, out_overflowed| one per finish
//
// Pushes stream back to back at one word per cycle while the scan is idle.
// A finish on n loaded elements produces its result once the scan has run all n pivots:
// the scan reads the store through its single read port once per pivot and once
// per compared element. A finish on an empty set gives its result the next cycle.
// Reset (rst_n low, synchronous) empties the set, clears the overflow flag and the
// result valid; the store itself is not cleared.
// Words are taken while the scan is idle; a finish also waits for the result
// register to drain, while pushes keep flowing behind a stalled result.
module array_mode_finder #(
  parameter int unsigned MAX_ELEMENTS = arm_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic                                     in_command,
  input  logic signed [arm_pkg::VALUE_W-1:0]       in_value,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [arm_pkg::VALUE_W-1:0]       out_mode_value,
  output logic [arm_pkg::MODE_COUNT_W-1:0]         out_mode_count,
  output logic                                     out_set_empty,
  output logic                                     out_overflowed
);
  import arm_pkg::*;

  localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

  arm_ctl_t                  ctl;
  arm_sts_t                  sts;
  logic signed [VALUE_W-1:0] core_value;
  logic [CW-1:0]             core_count;
  logic [CW+MODE_COUNT_W-1:0] count_ext;

  logic [CW-1:0]             fill_r;
  logic                      ovf_r;
  logic                      ovf_hold_r;
  logic                      out_vld_r;
  logic signed [VALUE_W-1:0] out_value_r;
  logic [MODE_COUNT_W-1:0]   out_count_r;
  logic                      out_empty_r;
  logic                      out_ovf_r;

  logic                      accept;
  logic                      push_acc;
  logic                      fin_acc;
  logic                      full;
  logic                      set_is_empty;

  // Hold off while scanning or while the last result pulse lands; a finish
  // also waits for the result register to drain.
  assign in_stall = sts.busy | sts.done | ((in_command == CMD_FINISH) & out_vld_r);

  assign accept       = in_valid & ~in_stall;
  assign push_acc     = accept & (in_command == CMD_PUSH);
  assign fin_acc      = accept & (in_command == CMD_FINISH);
  assign full         = (fill_r == CW'(MAX_ELEMENTS));
  assign set_is_empty = (fill_r == '0);

  // Drop pushes into a full store.
  assign ctl.push  = push_acc & ~full;
  assign ctl.start = fin_acc & ~set_is_empty;

  // Mask or widen the scan count to the reported width.
  assign count_ext = {{MODE_COUNT_W{1'b0}}, core_count};

  arm_core #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .AW           (AW),
    .CW           (CW)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .wr_addr    (fill_r[AW-1:0]),
    .wr_data    (in_value),
    .num_elems  (fill_r),
    .sts        (sts),
    .best_value (core_value),
    .best_count (core_count)
  );

  // Control: fill count, overflow tracking, result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      ovf_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (push_acc) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          fill_r <= CW'(fill_r + 1'b1);
        end
      end
      if (fin_acc) begin
        fill_r <= '0;
        ovf_r  <= 1'b0;
      end
      priority if (fin_acc && set_is_empty) begin
        out_vld_r <= 1'b1;
      end else if (sts.done) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && !out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload: result fields and the overflow flag latched at finish.
  always_ff @(posedge clk) begin
    if (fin_acc) begin
      ovf_hold_r <= ovf_r;
    end
    priority if (fin_acc && set_is_empty) begin
      out_value_r <= EMPTY_VALUE;
      out_count_r <= '0;
      out_empty_r <= 1'b1;
      out_ovf_r   <= ovf_r;
    end else if (sts.done) begin
      out_value_r <= core_value;
      out_count_r <= count_ext[MODE_COUNT_W-1:0];
      out_empty_r <= 1'b0;
      out_ovf_r   <= ovf_hold_r;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_mode_value = out_value_r;
  assign out_mode_count = out_count_r;
  assign out_set_empty  = out_empty_r;
  assign out_overflowed = out_ovf_r;

endmodule

// ===== sv/arm_checker.sv =====
// Port-level checker for the array mode finder and its bind.
module arm_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 in_command,
  input logic signed [arm_pkg::VALUE_W-1:0]   in_value,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [arm_pkg::VALUE_W-1:0]   out_mode_value,
  input logic [arm_pkg::MODE_COUNT_W-1:0]     out_mode_count,
  input logic                                 out_set_empty,
  input logic                                 out_overflowed
);
  import arm_pkg::*;

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mode_value)
      && $stable(out_mode_count) && $stable(out_set_empty) && $stable(out_overflowed))
    else $error("stalled result word changed");

  // Empty-set results carry the fixed value and a zero count.
  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_set_empty |-> out_mode_value == EMPTY_VALUE && out_mode_count == '0)
    else $error("empty result with wrong fields");

  // A non-empty result counts at least one occurrence.
  a_nonempty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_set_empty |-> out_mode_count != '0)
    else $error("non-empty result with zero count");

  // A finish is taken only once the result register is free.
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command == CMD_FINISH |-> !out_valid)
    else $error("finish accepted while a result waits");

  // A taken result is not followed by another in the next cycle.
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("result repeated after being taken");

endmodule

bind array_mode_finder arm_checker u_arm_checker (.*);

// ===== sim/tb_array_mode_finder.sv =====
// Self-checking testbench for array_mode_finder: directed table, random sets, scoreboard.
`timescale 1ns / 100ps

module tb_array_mode_finder;
  import arm_pkg::*;

  localparam int unsigned MAX_SET    = MAX_ELEMENTS_DEF;
  localparam int          RAND_WORDS = 550;
  // Allow several times the whole run, full-set scan included.
  localparam longint      CYCLE_LIMIT = 4_000_000;

  // One mode report as it leaves the result channel
  typedef struct packed {
    logic signed [VALUE_W-1:0] mode_value;
    logic [MODE_COUNT_W-1:0]   mode_count;
    logic                      set_empty;
    logic                      overflowed;
  } mode_rpt_t;

  // One row of the directed table; reps repeats the same word
  typedef struct packed {
    logic                      cmd;
    logic signed [VALUE_W-1:0] val;
    logic [10:0]               reps;
    logic                      typed;
    mode_rpt_t                 want;
  } stim_row_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic                             in_command;
  logic signed [VALUE_W-1:0]        in_value;
  logic                             out_valid;
  logic                             out_stall;
  logic signed [VALUE_W-1:0]        out_mode_value;
  logic [MODE_COUNT_W-1:0]          out_mode_count;
  logic                             out_set_empty;
  logic                             out_overflowed;

  // Shadow copy of the set being loaded
  logic signed [VALUE_W-1:0] set_mem [MAX_SET];
  int unsigned               set_fill;
  bit                        set_ovf;

  // Reports owed by the block, oldest first
  mode_rpt_t pending_modes[$];

  int     fail_count;
  int     words_in;
  int     reports_seen;
  int     largest_set;
  int     ovf_reports;
  bit     calm;
  longint cycle_count;

  array_mode_finder #(
    .MAX_ELEMENTS(MAX_SET)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_mode_value(out_mode_value),
    .out_mode_count(out_mode_count),
    .out_set_empty (out_set_empty),
    .out_overflowed(out_overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fold one accepted word into the shadow set. A finish yields the mode
  // by pairwise counting: for each position, count equal elements and keep
  // the first strictly larger count, so ties go to the earliest position.
  function automatic void tally_word(input logic cmd, input logic signed [VALUE_W-1:0] val,
                                     output bit got, output mode_rpt_t rpt);
    int unsigned best_n;
    int unsigned best_at;
    int unsigned run;
    got = 1'b0;
    rpt = '0;
    if (cmd == CMD_PUSH) begin
      // Drop the word once the set is full, but remember that one was dropped.
      if (set_fill < MAX_SET) begin
        set_mem[set_fill] = val;
        set_fill++;
      end else begin
        set_ovf = 1'b1;
      end
    end else begin
      got = 1'b1;
      rpt.overflowed = set_ovf;
      if (set_fill == 0) begin
        rpt.mode_value = EMPTY_VALUE;
        rpt.mode_count = '0;
        rpt.set_empty  = 1'b1;
      end else begin
        best_n  = 0;
        best_at = 0;
        for (int unsigned i = 0; i < set_fill; i++) begin
          run = 0;
          for (int unsigned j = 0; j < set_fill; j++) begin
            if (set_mem[j] == set_mem[i]) run++;
          end
          if (run > best_n) begin
            best_n  = run;
            best_at = i;
          end
        end
        rpt.mode_value = set_mem[best_at];
        rpt.mode_count = best_n[MODE_COUNT_W-1:0];
        rpt.set_empty  = 1'b0;
      end
      if (set_fill > largest_set) largest_set = set_fill;
      // Clear the set for the next one; stale store contents are never read.
      set_fill = 0;
      set_ovf  = 1'b0;
    end
  endfunction

  function automatic stim_row_t mk_row(input logic cmd, input logic signed [VALUE_W-1:0] val,
                                       input int reps = 1, input bit typed = 1'b0,
                                       input logic signed [VALUE_W-1:0] mv = '0,
                                       input int mc = 0, input bit me = 1'b0,
                                       input bit mo = 1'b0);
    stim_row_t r;
    r.cmd             = cmd;
    r.val             = val;
    r.reps            = reps[10:0];
    r.typed           = typed;
    r.want.mode_value = mv;
    r.want.mode_count = mc[MODE_COUNT_W-1:0];
    r.want.set_empty  = me;
    r.want.overflowed = mo;
    return r;
  endfunction

  // Offer one word and hold it until the block takes it. A typed row
  // replaces the predicted report with the one written in the table.
  task automatic send_word(input logic cmd, input logic signed [VALUE_W-1:0] val,
                           input bit typed = 1'b0, input mode_rpt_t want = '0);
    bit        got;
    mode_rpt_t rpt;
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_value   <= val;
    // Look at stall mid-cycle, once the edge's updates have settled.
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    words_in++;
    tally_word(cmd, val, got, rpt);
    if (got) pending_modes.push_back(typed ? want : rpt);
  endtask

  // Drop valid for a random gap now and then, except in a calm stretch.
  task automatic idle_gap();
    if (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  // Hold the sender until every owed report has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_modes.size() != 0);
  endtask

  // Receiver: stall about 8 percent of the time, never while calm.
  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 8);
  end

  // Scoreboard: compare each accepted report with the oldest one owed.
  always @(posedge clk) begin : check_results
    mode_rpt_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_modes.size() == 0) begin
        $error("unexpected result word: mode_value %0d mode_count %0d", out_mode_value,
               out_mode_count);
        fail_count++;
      end else begin
        want = pending_modes.pop_front();
        reports_seen++;
        if (want.overflowed) ovf_reports++;
        if (out_mode_value !== want.mode_value) begin
          $error("mode_value: expected %0d, got %0d", want.mode_value, out_mode_value);
          fail_count++;
        end
        if (out_mode_count !== want.mode_count) begin
          $error("mode_count: expected %0d, got %0d", want.mode_count, out_mode_count);
          fail_count++;
        end
        if (out_set_empty !== want.set_empty) begin
          $error("set_empty: expected %0b, got %0b", want.set_empty, out_set_empty);
          fail_count++;
        end
        if (out_overflowed !== want.overflowed) begin
          $error("overflowed: expected %0b, got %0b", want.overflowed, out_overflowed);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL array_mode_finder");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t                 dir_rows[$];
    logic signed [VALUE_W-1:0] pool [4];
    int                        base;
    int                        n_set;
    bit                        wild;

    // Drive every input to a known value before the first edge.
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_command   <= CMD_PUSH;
    in_value     <= '0;
    out_stall    <= 1'b0;
    cycle_count  = 0;
    fail_count   = 0;
    words_in     = 0;
    reports_seen = 0;
    largest_set  = 0;
    ovf_reports  = 0;
    calm         = 1'b0;
    set_fill     = 0;
    set_ovf      = 1'b0;

    // Directed words: extremes, ties, the ignored value of a finish, the
    // empty set, a full set with dropped pushes, and the flag clearing after.
    dir_rows.push_back(mk_row(CMD_FINISH, 32'sd0, 1, 1'b1, EMPTY_VALUE, 0, 1'b1, 1'b0));
    dir_rows.push_back(mk_row(CMD_PUSH, 32'sh7FFF_FFFF));
    dir_rows.push_back(mk_row(CMD_FINISH, 32'sd0, 1, 1'b1, 32'sh7FFF_FFFF, 1, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(CMD_PUSH, 32'sh8000_0000));
    dir_rows.push_back(mk_row(CMD_PUSH, 32'sh8000_0000));
    dir_rows.push_back(mk_row(CMD_PUSH, 32'sh7FFF_FFFF));
    dir_rows.push_back(mk_row(CMD_FINISH, 32'sd0, 1, 1'b1, 32'sh8000_0000, 2, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(CMD_PUSH, 32'sd5));
    dir_rows.push_back(mk_row(CMD_PUSH, -32'sd3));
    dir_rows.push_back(mk_row(CMD_PUSH, -32'sd3));
    dir_rows.push_back(mk_row(CMD_PUSH, 32'sd5));
    dir_rows.push_back(mk_row(CMD_FINISH, -32'sd1));
    dir_rows.push_back(mk_row(CMD_PUSH, -32'sd1));
    dir_rows.push_back(mk_row(CMD_FINISH, 32'sh5555_5555));
    dir_rows.push_back(mk_row(CMD_PUSH, 32'sd0, 3));
    dir_rows.push_back(mk_row(CMD_PUSH, 32'sh5555_5555, 3));
    dir_rows.push_back(mk_row(CMD_FINISH, 32'shAAAA_AAAA));
    dir_rows.push_back(mk_row(CMD_PUSH, 32'sh5A5A_A5A5, MAX_SET));
    dir_rows.push_back(mk_row(CMD_PUSH, 32'shA5A5_5A5A, 2));
    dir_rows.push_back(mk_row(CMD_FINISH, 32'sd0, 1, 1'b1, 32'sh5A5A_A5A5, MAX_SET,
                              1'b0, 1'b1));
    dir_rows.push_back(mk_row(CMD_FINISH, 32'sd0, 1, 1'b1, EMPTY_VALUE, 0, 1'b1, 1'b0));

    // Reset once.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      repeat (dir_rows[k].reps) begin
        send_word(dir_rows[k].cmd, dir_rows[k].val, dir_rows[k].typed, dir_rows[k].want);
        idle_gap();
      end
    end

    // Let the directed reports settle before going random.
    drain_results();

    // Random part: mostly whole sets (pushes then a finish), drawn either from
    // a four-value pool to force repeats and ties, or from the full range.
    // Now and then a lone word breaks a set or finishes an empty one.
    base = words_in;
    while (words_in - base < RAND_WORDS) begin
      calm = (words_in - base >= 250) && (words_in - base < 380);
      if ($urandom_range(99) < 8) begin
        send_word($urandom_range(1), $urandom);
        idle_gap();
      end else begin
        n_set = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 0);
        wild  = ($urandom_range(3) == 0);
        foreach (pool[p]) pool[p] = $urandom;
        if ($urandom_range(11) == 0) drain_results();
        repeat (n_set) begin
          send_word(CMD_PUSH, wild ? $urandom : pool[$urandom_range(3)]);
          idle_gap();
        end
        send_word(CMD_FINISH, $urandom);
        idle_gap();
      end
    end
    calm = 1'b0;

    // Wait out the last reports, then watch a while for stray ones.
    drain_results();
    repeat (50) @(posedge clk);

    $display("Run covered %0d words in and %0d mode reports, largest set %0d elements,",
             words_in, reports_seen, largest_set);
    $display("%0d reports with dropped pushes, %0d mismatches.", ovf_reports, fail_count);
    if (fail_count == 0) begin
      $display("PASS array_mode_finder");
    end else begin
      $display("FAIL array_mode_finder");
    end
    $finish;
  end

endmodule
